@@ design/lpcd_pkg.sv @@
// Shared types and codes for the LRU page cache directory.
// Depends on nothing; the compare unit, sequencer and top design files import it.
`default_nettype none

package lpcd_pkg;

  // Request function codes.
  localparam logic FUNC_FIND  = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  localparam int unsigned PAGE_ID_W = 32;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned SLOT_W    = 4;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STAT_HIT     = 3'd0,
    STAT_FILL    = 3'd1,
    STAT_EVICT   = 3'd2,
    STAT_INVALID = 3'd3,
    STAT_CLEARED = 3'd4
  } status_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_AGE,
    S_COMMIT,
    S_RESP
  } state_e;

  // Flags from the shared compare unit for one directory entry.
  typedef struct packed {
    logic tag_hit;
    logic rank_lru;
    logic age_ok;
  } cmp_flags_t;

endpackage

`default_nettype wire

@@ design/lpcd_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`default_nettype none

module lpcd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read in the same cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ design/lpcd_cmp.sv @@
// Shared compare unit: tag match, LRU rank test and aging decision for one entry.
// Depends on lpcd_pkg.
`default_nettype none

module lpcd_cmp #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire logic [lpcd_pkg::PAGE_ID_W-1:0] tag_i,
  input  wire logic [lpcd_pkg::PAGE_ID_W-1:0] id_i,
  input  wire logic [$clog2(ENTRIES)-1:0]     rank_i,
  input  wire logic [$clog2(ENTRIES)-1:0]     idx_i,
  input  wire logic [$clog2(ENTRIES)-1:0]     limit_i,
  input  wire logic                           age_all_i,
  input  wire logic                           skip_en_i,
  input  wire logic [$clog2(ENTRIES)-1:0]     skip_idx_i,
  output lpcd_pkg::cmp_flags_t                flags_o,
  output logic      [$clog2(ENTRIES)-1:0]     rank_inc_o
);

  import lpcd_pkg::*;

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam logic [IW-1:0] LRU_RANK = IW'(ENTRIES - 1);

  // An entry ages if not the enabled skip slot and age_all or rank < limit holds.
  always_comb begin
    flags_o.tag_hit  = (tag_i == id_i);
    flags_o.rank_lru = (rank_i == LRU_RANK);
    flags_o.age_ok   = !(skip_en_i && (idx_i == skip_idx_i)) &&
                       (age_all_i || (rank_i < limit_i));
  end

  assign rank_inc_o = rank_i + IW'(1);

endmodule

`default_nettype wire

@@ design/lpcd_seq.sv @@
// Sequencer of the page cache directory: scans tags, ages ranks, commits and reports.
// Depends on lpcd_pkg; drives the tag and rank RAMs and the shared compare unit.
`default_nettype none

module lpcd_seq #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Request side.
  input  wire logic                           start_i,
  output logic                                busy_o,
  input  wire logic                           func_i,
  input  wire logic [lpcd_pkg::PAGE_ID_W-1:0] page_id_i,
  // Result side.
  output logic                                valid_o,
  output logic      [lpcd_pkg::STATUS_W-1:0]  status_o,
  output logic      [lpcd_pkg::SLOT_W-1:0]    slot_o,
  output logic      [lpcd_pkg::PAGE_ID_W-1:0] victim_id_o,
  // RAM ports.
  output logic      [$clog2(ENTRIES)-1:0]     raddr_o,
  input  wire logic [lpcd_pkg::PAGE_ID_W-1:0] tag_rd_i,
  input  wire logic [$clog2(ENTRIES)-1:0]     rank_rd_i,
  output logic      [$clog2(ENTRIES)-1:0]     waddr_o,
  output logic                                tag_we_o,
  output logic      [lpcd_pkg::PAGE_ID_W-1:0] tag_wdata_o,
  output logic                                rank_we_o,
  output logic      [$clog2(ENTRIES)-1:0]     rank_wdata_o,
  // Compare unit.
  input  wire lpcd_pkg::cmp_flags_t           flags_i,
  input  wire logic [$clog2(ENTRIES)-1:0]     rank_inc_i,
  output logic      [lpcd_pkg::PAGE_ID_W-1:0] id_o,
  output logic      [$clog2(ENTRIES)-1:0]     idx_o,
  output logic      [$clog2(ENTRIES)-1:0]     limit_o,
  output logic                                age_all_o,
  output logic                                skip_en_o,
  output logic      [$clog2(ENTRIES)-1:0]     skip_idx_o
);

  import lpcd_pkg::*;

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned EW = (IW > SLOT_W) ? IW : SLOT_W;
  localparam logic [CW-1:0] FULL_COUNT = CW'(ENTRIES);
  localparam logic [IW-1:0] LRU_LIMIT  = IW'(ENTRIES - 1);

  state_e             state_q, state_d;
  logic [CW-1:0]      count_q, count_d;
  logic [PAGE_ID_W-1:0] id_q, id_d;
  logic [CW-1:0]      idx_q, idx_d;
  logic [IW-1:0]      pidx_q, pidx_d;
  logic               pvalid_q, pvalid_d;
  logic               hit_found_q, hit_found_d;
  logic [IW-1:0]      hit_idx_q, hit_idx_d;
  logic [IW-1:0]      hit_rank_q, hit_rank_d;
  logic               lru_found_q, lru_found_d;
  logic [IW-1:0]      lru_idx_q, lru_idx_d;
  logic [PAGE_ID_W-1:0] victim_q, victim_d;
  logic [PAGE_ID_W-1:0] first_tag_q, first_tag_d;
  logic [IW-1:0]      target_q, target_d;
  logic [IW-1:0]      limit_q, limit_d;
  logic               age_all_q, age_all_d;
  logic               skip_en_q, skip_en_d;
  status_e            status_q, status_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;

  logic               accept;
  logic               issue;
  logic               drained;
  logic [EW-1:0]      target_ext;

  assign accept  = start_i && (state_q == S_IDLE);
  assign issue   = (idx_q < count_q);
  assign drained = !issue && !pvalid_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if ((func_i == FUNC_CLEAR) || (page_id_i == '0)) begin
            state_d = S_RESP;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (drained) begin
          state_d = S_AGE;
        end
      end
      S_AGE: begin
        if (drained) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: state_d = S_RESP;
      S_RESP:   state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Datapath updates for each phase.
  always_comb begin
    count_d     = count_q;
    id_d        = id_q;
    idx_d       = idx_q;
    pidx_d      = pidx_q;
    pvalid_d    = 1'b0;
    hit_found_d = hit_found_q;
    hit_idx_d   = hit_idx_q;
    hit_rank_d  = hit_rank_q;
    lru_found_d = lru_found_q;
    lru_idx_d   = lru_idx_q;
    victim_d    = victim_q;
    first_tag_d = first_tag_q;
    target_d    = target_q;
    limit_d     = limit_q;
    age_all_d   = age_all_q;
    skip_en_d   = skip_en_q;
    status_d    = status_q;
    slot_d      = slot_q;
    target_ext  = EW'(target_q);
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          slot_d   = '0;
          victim_d = '0;
          if (func_i == FUNC_CLEAR) begin
            count_d  = '0;
            status_d = STAT_CLEARED;
          end else if (page_id_i == '0) begin
            status_d = STAT_INVALID;
          end else begin
            id_d        = page_id_i;
            idx_d       = '0;
            hit_found_d = 1'b0;
            lru_found_d = 1'b0;
          end
        end
      end
      // Walk the occupied slots; record the first tag match and the first LRU slot.
      S_SCAN: begin
        if (issue) begin
          idx_d    = idx_q + CW'(1);
          pvalid_d = 1'b1;
          pidx_d   = idx_q[IW-1:0];
        end
        if (pvalid_q) begin
          if (pidx_q == '0) begin
            first_tag_d = tag_rd_i;
          end
          if (flags_i.tag_hit && !hit_found_q) begin
            hit_found_d = 1'b1;
            hit_idx_d   = pidx_q;
            hit_rank_d  = rank_rd_i;
          end
          if (flags_i.rank_lru && !lru_found_q) begin
            lru_found_d = 1'b1;
            lru_idx_d   = pidx_q;
            victim_d    = tag_rd_i;
          end
        end
        // Pick hit, fill or eviction once the scan has drained.
        if (drained) begin
          idx_d = '0;
          if (hit_found_q) begin
            status_d  = STAT_HIT;
            target_d  = hit_idx_q;
            limit_d   = hit_rank_q;
            age_all_d = 1'b0;
            skip_en_d = 1'b1;
            victim_d  = '0;
          end else if (count_q < FULL_COUNT) begin
            status_d  = STAT_FILL;
            target_d  = count_q[IW-1:0];
            limit_d   = LRU_LIMIT;
            age_all_d = 1'b1;
            skip_en_d = 1'b0;
            victim_d  = '0;
          end else begin
            status_d  = STAT_EVICT;
            target_d  = lru_found_q ? lru_idx_q : '0;
            limit_d   = LRU_LIMIT;
            age_all_d = 1'b0;
            skip_en_d = 1'b1;
            victim_d  = lru_found_q ? victim_q : first_tag_q;
          end
        end
      end
      // Read-modify-write pass over the ranks, one slot per cycle.
      S_AGE: begin
        if (issue) begin
          idx_d    = idx_q + CW'(1);
          pvalid_d = 1'b1;
          pidx_d   = idx_q[IW-1:0];
        end
      end
      S_COMMIT: begin
        if (status_q == STAT_FILL) begin
          count_d = count_q + CW'(1);
        end
        slot_d = target_ext[SLOT_W-1:0];
      end
      S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  // RAM and compare unit controls.
  always_comb begin
    raddr_o      = idx_q[IW-1:0];
    waddr_o      = pidx_q;
    tag_we_o     = 1'b0;
    tag_wdata_o  = id_q;
    rank_we_o    = 1'b0;
    rank_wdata_o = rank_inc_i;
    case (state_q)
      S_AGE: begin
        rank_we_o = pvalid_q && flags_i.age_ok;
      end
      S_COMMIT: begin
        waddr_o      = target_q;
        tag_we_o     = 1'b1;
        rank_we_o    = 1'b1;
        rank_wdata_o = '0;
      end
      default: begin
      end
    endcase
  end

  assign id_o       = id_q;
  assign idx_o      = pidx_q;
  assign limit_o    = limit_q;
  assign age_all_o  = age_all_q;
  assign skip_en_o  = skip_en_q;
  assign skip_idx_o = target_q;

  assign busy_o      = (state_q != S_IDLE);
  assign valid_o     = (state_q == S_RESP);
  assign status_o    = status_q;
  assign slot_o      = slot_q;
  assign victim_id_o = victim_q;

  // Control state resets; payload registers are loaded before use.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      pvalid_q    <= 1'b0;
      hit_found_q <= 1'b0;
      lru_found_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      pvalid_q    <= pvalid_d;
      hit_found_q <= hit_found_d;
      lru_found_q <= lru_found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q        <= id_d;
    pidx_q      <= pidx_d;
    hit_idx_q   <= hit_idx_d;
    hit_rank_q  <= hit_rank_d;
    lru_idx_q   <= lru_idx_d;
    victim_q    <= victim_d;
    first_tag_q <= first_tag_d;
    target_q    <= target_d;
    limit_q     <= limit_d;
    age_all_q   <= age_all_d;
    skip_en_q   <= skip_en_d;
    status_q    <= status_d;
    slot_q      <= slot_d;
  end

endmodule

`default_nettype wire

@@ design/lru_page_cache_directory.sv @@
// LRU page cache directory, fully associative, CACHE_ENTRIES slots.
// Latency: clear and invalid-id requests give their result 1 cycle after acceptance;
// a find runs the tag scan and then the rank aging pass over the occupied slots,
// one entry per cycle over the RAM read port, then commits the slot and reports.
// Throughput: one request at a time; busy stays high through the one-cycle result strobe,
// which cannot be stalled. Reset empties the directory at once (fill count cleared).
// Depends on lpcd_pkg, lpcd_ram, lpcd_cmp and lpcd_seq.
`default_nettype none

module lru_page_cache_directory #(
  parameter int unsigned CACHE_ENTRIES = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic                           func_i,
  input  wire logic [lpcd_pkg::PAGE_ID_W-1:0] page_id_i,
  output logic                                valid_o,
  output logic      [lpcd_pkg::STATUS_W-1:0]  status_o,
  output logic      [lpcd_pkg::SLOT_W-1:0]    slot_o,
  output logic      [lpcd_pkg::PAGE_ID_W-1:0] victim_id_o
);

  import lpcd_pkg::*;

  localparam int unsigned IW = $clog2(CACHE_ENTRIES);

  logic [IW-1:0]        raddr;
  logic [IW-1:0]        waddr;
  logic [PAGE_ID_W-1:0] tag_rd;
  logic [IW-1:0]        rank_rd;
  logic                 tag_we;
  logic [PAGE_ID_W-1:0] tag_wdata;
  logic                 rank_we;
  logic [IW-1:0]        rank_wdata;
  cmp_flags_t           flags;
  logic [IW-1:0]        rank_inc;
  logic [PAGE_ID_W-1:0] cmp_id;
  logic [IW-1:0]        cmp_idx;
  logic [IW-1:0]        cmp_limit;
  logic                 cmp_age_all;
  logic                 cmp_skip_en;
  logic [IW-1:0]        cmp_skip_idx;

  // Page id held by each slot.
  lpcd_ram #(
    .WIDTH (PAGE_ID_W),
    .DEPTH (CACHE_ENTRIES)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (waddr),
    .wdata_i (tag_wdata),
    .raddr_i (raddr),
    .rdata_o (tag_rd)
  );

  // Recency rank of each slot, 0 most recent.
  lpcd_ram #(
    .WIDTH (IW),
    .DEPTH (CACHE_ENTRIES)
  ) u_rank_ram (
    .clk_i   (clk_i),
    .we_i    (rank_we),
    .waddr_i (waddr),
    .wdata_i (rank_wdata),
    .raddr_i (raddr),
    .rdata_o (rank_rd)
  );

  // Shared compare unit working on the entry just read.
  lpcd_cmp #(
    .ENTRIES (CACHE_ENTRIES)
  ) u_cmp (
    .tag_i      (tag_rd),
    .id_i       (cmp_id),
    .rank_i     (rank_rd),
    .idx_i      (cmp_idx),
    .limit_i    (cmp_limit),
    .age_all_i  (cmp_age_all),
    .skip_en_i  (cmp_skip_en),
    .skip_idx_i (cmp_skip_idx),
    .flags_o    (flags),
    .rank_inc_o (rank_inc)
  );

  // Request sequencer.
  lpcd_seq #(
    .ENTRIES (CACHE_ENTRIES)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_o       (busy),
    .func_i       (func_i),
    .page_id_i    (page_id_i),
    .valid_o      (valid_o),
    .status_o     (status_o),
    .slot_o       (slot_o),
    .victim_id_o  (victim_id_o),
    .raddr_o      (raddr),
    .tag_rd_i     (tag_rd),
    .rank_rd_i    (rank_rd),
    .waddr_o      (waddr),
    .tag_we_o     (tag_we),
    .tag_wdata_o  (tag_wdata),
    .rank_we_o    (rank_we),
    .rank_wdata_o (rank_wdata),
    .flags_i      (flags),
    .rank_inc_i   (rank_inc),
    .id_o         (cmp_id),
    .idx_o        (cmp_idx),
    .limit_o      (cmp_limit),
    .age_all_o    (cmp_age_all),
    .skip_en_o    (cmp_skip_en),
    .skip_idx_o   (cmp_skip_idx)
  );

endmodule

`default_nettype wire

@@ sim/lpcd_checker.sv @@
// Request/reply checker for the LRU page cache directory testbench.
// Keeps its own copy of the directory, predicts each reply and compares it.
// Depends on lpcd_pkg for the function and status codes.
`timescale 1ns / 100ps

module lpcd_checker #(
  parameter int unsigned CACHE_ENTRIES = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic                           busy_i,
  input  wire logic                           func_i,
  input  wire logic [lpcd_pkg::PAGE_ID_W-1:0] page_id_i,
  input  wire logic                           valid_i,
  input  wire logic [lpcd_pkg::STATUS_W-1:0]  status_i,
  input  wire logic [lpcd_pkg::SLOT_W-1:0]    slot_i,
  input  wire logic [lpcd_pkg::PAGE_ID_W-1:0] victim_id_i,
  output int                                  pending_o,
  output int                                  fail_count_o
);
  import lpcd_pkg::*;

  typedef struct {
    status_e               status;
    logic [SLOT_W-1:0]     slot;
    logic [PAGE_ID_W-1:0]  victim;
  } reply_t;

  // Replies still owed by the block, oldest first.
  reply_t awaited_replies[$];

  // Shadow copy of the directory.
  logic [PAGE_ID_W-1:0] page_tag [CACHE_ENTRIES];
  int unsigned          age_rank [CACHE_ENTRIES];
  int unsigned          used_slots;
  int                   mismatches = 0;

  // Age every occupied slot younger than limit, leaving slot skip alone.
  task automatic age_slots(input int unsigned limit, input int unsigned skip);
    for (int unsigned i = 0; i < used_slots; i++) begin
      if (i != skip && age_rank[i] < limit) begin
        age_rank[i] = age_rank[i] + 1;
      end
    end
  endtask

  // Apply one request to the shadow directory and return the reply it earns.
  task automatic lookup_page(input logic func, input logic [PAGE_ID_W-1:0] id,
                             output reply_t reply);
    int unsigned hit_slot;
    int unsigned target;
    bit          found;
    reply.status = STAT_HIT;
    reply.slot   = '0;
    reply.victim = '0;
    found        = 1'b0;
    hit_slot     = 0;
    target       = 0;
    if (func == FUNC_CLEAR) begin
      for (int unsigned i = 0; i < CACHE_ENTRIES; i++) begin
        page_tag[i] = '0;
        age_rank[i] = 0;
      end
      used_slots   = 0;
      reply.status = STAT_CLEARED;
    end else if (id == '0) begin
      reply.status = STAT_INVALID;
    end else begin
      for (int unsigned i = 0; i < used_slots; i++) begin
        if (!found && page_tag[i] == id) begin
          found    = 1'b1;
          hit_slot = i;
        end
      end
      if (found) begin
        // A hit moves the slot to the front; only younger slots age.
        age_slots(age_rank[hit_slot], hit_slot);
        age_rank[hit_slot] = 0;
        reply.status       = STAT_HIT;
        reply.slot         = SLOT_W'(hit_slot);
      end else if (used_slots < CACHE_ENTRIES) begin
        // Free slots are taken in physical order.
        target = used_slots;
        age_slots(CACHE_ENTRIES, CACHE_ENTRIES);
        used_slots       = used_slots + 1;
        page_tag[target] = id;
        age_rank[target] = 0;
        reply.status     = STAT_FILL;
        reply.slot       = SLOT_W'(target);
      end else begin
        // Full: the oldest slot is reused and its page goes back as the victim.
        for (int unsigned i = 0; i < CACHE_ENTRIES; i++) begin
          if (!found && age_rank[i] == CACHE_ENTRIES - 1) begin
            found  = 1'b1;
            target = i;
          end
        end
        reply.victim = page_tag[target];
        age_slots(CACHE_ENTRIES - 1, target);
        page_tag[target] = id;
        age_rank[target] = 0;
        reply.status     = STAT_EVICT;
        reply.slot       = SLOT_W'(target);
      end
    end
  endtask

  // Compare replies first, then record a request accepted at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    reply_t oldest;
    reply_t fresh;
    if (!rst_ni) begin
      for (int unsigned i = 0; i < CACHE_ENTRIES; i++) begin
        page_tag[i] = '0;
        age_rank[i] = 0;
      end
      used_slots = 0;
      awaited_replies.delete();
    end else begin
      if (valid_i) begin
        if (awaited_replies.size() == 0) begin
          mismatches++;
          $display("%0t: reply with no request waiting: status %0d slot %0d victim %h",
                   $time, status_i, slot_i, victim_id_i);
        end else begin
          oldest = awaited_replies.pop_front();
          if (status_i !== oldest.status) begin
            mismatches++;
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, oldest.status, status_i);
          end
          if (slot_i !== oldest.slot) begin
            mismatches++;
            $display("%0t: slot mismatch: expected %0d, actual %0d",
                     $time, oldest.slot, slot_i);
          end
          if (victim_id_i !== oldest.victim) begin
            mismatches++;
            $display("%0t: victim_id mismatch: expected %h, actual %h",
                     $time, oldest.victim, victim_id_i);
          end
        end
      end
      if (start_i && !busy_i) begin
        lookup_page(func_i, page_id_i, fresh);
        awaited_replies.push_back(fresh);
      end
    end
    pending_o    = awaited_replies.size();
    fail_count_o = mismatches;
  end

endmodule

@@ sim/tb_lru_page_cache_directory.sv @@
// Top of the LRU page cache directory testbench: clock, reset and request stimulus.
// Depends on lpcd_pkg, the block lru_page_cache_directory and the lpcd_checker module.
`timescale 1ns / 100ps

module tb_lru_page_cache_directory;
  import lpcd_pkg::*;

  localparam int unsigned ENTRIES         = 16;
  localparam int unsigned RANDOM_REQUESTS = 1550;
  localparam int unsigned DRAIN_LIMIT     = 5000;
  localparam int unsigned TAIL_CYCLES     = 80;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic                 func;
  logic [PAGE_ID_W-1:0] page_id;
  logic                 valid;
  logic [STATUS_W-1:0]  status;
  logic [SLOT_W-1:0]    slot;
  logic [PAGE_ID_W-1:0] victim_id;
  int                   pending;
  int                   fail_count;
  int unsigned          quiet_left = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  lru_page_cache_directory #(
    .CACHE_ENTRIES(ENTRIES)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .func_i     (func),
    .page_id_i  (page_id),
    .valid_o    (valid),
    .status_o   (status),
    .slot_o     (slot),
    .victim_id_o(victim_id)
  );

  lpcd_checker #(
    .CACHE_ENTRIES(ENTRIES)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .func_i      (func),
    .page_id_i   (page_id),
    .valid_i     (valid),
    .status_i    (status),
    .slot_i      (slot),
    .victim_id_i (victim_id),
    .pending_o   (pending),
    .fail_count_o(fail_count)
  );

  // Offer one request after a random idle gap, which may be zero, and hold it until it is taken.
  task automatic send_request(input logic req_func, input logic [PAGE_ID_W-1:0] req_id);
    int unsigned gap;
    int unsigned roll;
    if (quiet_left > 0) begin
      gap        = 0;
      quiet_left = quiet_left - 1;
    end else begin
      roll = $urandom_range(99);
      if (roll < 55) begin
        gap = 0;
      end else if (roll < 90) begin
        gap = $urandom_range(3, 1);
      end else begin
        gap = $urandom_range(60, 5);
      end
      // Now and then run a stretch of back-to-back requests.
      if ($urandom_range(99) < 3) begin
        quiet_left = $urandom_range(40, 10);
      end
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start   <= 1'b1;
    func    <= req_func;
    page_id <= req_id;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Hard stop in case the block hangs.
  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    logic [PAGE_ID_W-1:0] pool [64];
    int unsigned          pool_size;
    int unsigned          phase_len;
    int unsigned          sent;
    int unsigned          roll;
    int unsigned          pick;
    int unsigned          cycles;

    rst_ni  <= 1'b0;
    start   <= 1'b0;
    func    <= FUNC_FIND;
    page_id <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: invalid id, extreme ids, a hit, filling up, an eviction, clears.
    send_request(FUNC_FIND, '0);
    send_request(FUNC_FIND, 32'hFFFF_FFFF);
    send_request(FUNC_FIND, 32'h0000_0001);
    send_request(FUNC_FIND, 32'hFFFF_FFFF);
    for (int unsigned i = 2; i < ENTRIES; i++) begin
      send_request(FUNC_FIND, PAGE_ID_W'(i));
    end
    send_request(FUNC_FIND, 32'h8000_0000);
    send_request(FUNC_FIND, 32'h0000_0007);
    send_request(FUNC_CLEAR, 32'hFFFF_FFFF);
    send_request(FUNC_FIND, 32'hFFFF_FFFF);
    send_request(FUNC_CLEAR, '0);

    // Random phases, each working on its own pool of page ids.
    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      roll = $urandom_range(99);
      if (roll < 25) begin
        pool_size = $urandom_range(8, 2);
      end else if (roll < 45) begin
        pool_size = ENTRIES;
      end else if (roll < 75) begin
        pool_size = $urandom_range(24, ENTRIES + 1);
      end else begin
        pool_size = $urandom_range(48, 25);
      end
      for (int unsigned k = 0; k < pool_size; k++) begin
        pool[k] = ($urandom_range(99) < 30) ? PAGE_ID_W'($urandom_range(40, 1)) : $urandom;
        if (pool[k] == '0) begin
          pool[k] = 32'h0000_0001;
        end
      end
      if ($urandom_range(99) < 30 && sent < RANDOM_REQUESTS) begin
        send_request(FUNC_CLEAR, $urandom);
        sent++;
      end
      phase_len = $urandom_range(80, 20);
      for (int unsigned j = 0; j < phase_len && sent < RANDOM_REQUESTS; j++) begin
        roll = $urandom_range(99);
        if (roll < 2) begin
          send_request(FUNC_CLEAR, $urandom);
        end else if (roll < 5) begin
          send_request(FUNC_FIND, '0);
        end else if (roll < 12) begin
          send_request(FUNC_FIND, $urandom);
        end else begin
          // Favor the first few pool entries so that recent pages come back often.
          if ($urandom_range(1) == 1) begin
            pick = $urandom_range((pool_size < 4) ? pool_size - 1 : 3);
          end else begin
            pick = $urandom_range(pool_size - 1);
          end
          send_request(FUNC_FIND, pool[pick]);
        end
        sent++;
      end
    end
    start <= 1'b0;

    // Wait for the last replies, then a few more cycles for stray strobes.
    cycles = 0;
    while (pending != 0 && cycles < DRAIN_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ lru_page_cache_directory.f @@
design/lpcd_pkg.sv
design/lpcd_ram.sv
design/lpcd_cmp.sv
design/lpcd_seq.sv
design/lru_page_cache_directory.sv
sim/lpcd_checker.sv
sim/tb_lru_page_cache_directory.sv
